>>> sv/rbu_pkg.sv
// Shared types and constants of the raw bank unpacker.
package rbu_pkg;

   // bank coding selected by the format register
   localparam logic [1:0] FMT_NONE    = 2'd0;
   localparam logic [1:0] FMT_ID_ADC  = 2'd1;
   localparam logic [1:0] FMT_PATTERN = 2'd2;
   localparam logic [1:0] FMT_ENTRIES = 2'd3;

   // configuration register indexes
   localparam logic REG_FORMAT   = 1'b0;
   localparam logic REG_SKIP_HDR = 1'b1;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_SKIP    = 3'd1,
      PH_PATTERN = 3'd2,
      PH_DATA    = 3'd3,
      PH_SPLIT   = 3'd4,
      PH_ENTRIES = 3'd5
   } phase_type;

   // one queued bank word
   typedef struct packed {
      logic [31:0] data_word;
      logic        first_of_bank;
   } word_type;

   // configuration seen by the parser
   typedef struct packed {
      logic [1:0] format_version;
      logic       skip_extra_header;
      logic       format_write;
   } csr_type;

   // one decoded result
   typedef struct packed {
      logic [8:0]         card_code;
      logic [5:0]         channel;
      logic [15:0]        cell_id;
      logic signed [15:0] adc_value;
      logic               last_in_word;
   } result_type;

endpackage

>>> sv/rbu_front.sv
// Input stage: accepts bank words and queues them for the parser.
module rbu_front import rbu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  word_type req_word,
   output logic     q_valid,
   input  logic     q_ready,
   output word_type q_word
);

   localparam int Depth = 4;
   localparam int PtrW  = $clog2(Depth);

   word_type            buf_mem [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]       count_ff, count_in;
   logic                push, pop;

   assign req_tready = (count_ff != (PtrW+1)'(Depth));
   assign q_valid    = (count_ff != '0);
   assign q_word     = buf_mem[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = q_valid && q_ready;

   // advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store incoming word
   always_ff @(posedge clock) begin
      if (push) begin
         buf_mem[wr_ptr_ff] <= req_word;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PtrW+1)'(Depth)) else $error("queue overfilled");

endmodule

>>> sv/rbu_parser.sv
// Back end: parses queued words and issues at most one result per cycle, stalling on rsp_ready.
module rbu_parser import rbu_pkg::*; #(
   parameter int CHANNELS_PER_CARD = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  csr_type    csr,
   input  logic       q_valid,
   output logic       q_ready,
   input  word_type   q_word,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_result
);

   localparam logic [5:0] CpcLim = 6'(CHANNELS_PER_CARD);

   logic        busy_ff, busy_in;
   logic [31:0] word_ff, word_in;
   phase_type   phase_ff, phase_in;
   logic [5:0]  skip_left_ff, skip_left_in;
   logic [5:0]  cc_ff, cc_in;
   logic [31:0] pat_ff, pat_in;
   logic [5:0]  bo_ff, bo_in;
   logic [7:0]  partial_ff, partial_in;
   logic [6:0]  el_ff, el_in;
   logic [8:0]  card_ff, card_in;
   logic [5:0]  off_ff, off_in;
   logic        half_ff, half_in;
   logic        rvalid_ff;
   result_type  rdata_ff;

   logic        slot_free, step_en, load;
   logic        emit;
   result_type  res;
   logic [31:0] shifted;
   logic [5:0]  cc_next;
   logic        cc_done, pat_bit;
   logic [15:0] short_adc, long_adc, split_adc;
   logic [3:0]  split_k;
   logic [31:0] split_w;
   logic [5:0]  off_short, off_long;
   logic [15:0] entry;
   logic [6:0]  el_dec;
   logic [7:0]  trig_sum;
   logic [5:0]  skip_new;
   logic [6:0]  el_new;

   assign slot_free = !rvalid_ff || rsp_ready;
   assign step_en   = busy_ff && slot_free;
   assign load      = !busy_ff && q_valid;
   assign q_ready   = !busy_ff;

   // shared datapath pieces
   assign shifted   = word_ff >> off_ff;
   assign cc_next   = cc_ff + 6'd1;
   assign cc_done   = (cc_next >= CpcLim);
   assign pat_bit   = pat_ff[cc_ff[4:0]];
   assign short_adc = {12'd0, shifted[3:0]} - 16'd8;
   assign long_adc  = {4'd0, shifted[11:0]} - 16'd256;
   assign split_k   = 4'(6'd12 - bo_ff);
   assign split_w   = word_ff << split_k;
   assign split_adc = {8'd0, partial_ff} + {4'd0, split_w[11:0]} - 16'd256;
   assign off_short = off_ff + 6'd4;
   assign off_long  = off_ff + 6'd12;
   assign entry     = half_ff ? word_ff[31:16] : word_ff[15:0];
   assign el_dec    = el_ff - 7'd1;
   assign trig_sum  = {1'b0, word_ff[6:0]} + 8'd3;
   assign skip_new  = trig_sum[7:2];
   assign el_new    = (csr.format_version == FMT_ENTRIES) ? word_ff[13:7] : 7'd0;

   // no result follows once the card ends, the word runs out or a split starts
   function automatic logic data_last(input logic [5:0] off_n, input logic done);
      logic nb;
      nb = pat_ff[cc_next[4:0]];
      return done || (off_n >= 6'd32) || (nb && (off_n > 6'd20));
   endfunction

   function automatic phase_type after_trigger(input logic [6:0] el);
      if (csr.format_version == FMT_PATTERN) begin
         return PH_PATTERN;
      end
      return (el != 7'd0) ? PH_ENTRIES : PH_HEADER;
   endfunction

   // result of the current step
   always_comb begin
      emit = 1'b0;
      res  = '0;
      res.card_code = card_ff;
      res.channel   = cc_ff;
      if (csr.format_version == FMT_ID_ADC) begin
         emit = 1'b1;
         res.card_code    = '0;
         res.channel      = '0;
         res.cell_id      = word_ff[31:16];
         res.adc_value    = word_ff[15:0];
         res.last_in_word = 1'b1;
      end else begin
         unique case (phase_ff)
            PH_SPLIT: begin
               emit = (csr.format_version == FMT_PATTERN);
               res.adc_value    = split_adc;
               res.last_in_word = data_last(bo_ff, cc_done);
            end
            PH_DATA: begin
               if (csr.format_version == FMT_PATTERN && off_ff < 6'd32) begin
                  if (!pat_bit) begin
                     emit = 1'b1;
                     res.adc_value    = short_adc;
                     res.last_in_word = data_last(off_short, cc_done);
                  end else if (off_ff <= 6'd20) begin
                     emit = 1'b1;
                     res.adc_value    = long_adc;
                     res.last_in_word = data_last(off_long, cc_done);
                  end
               end
            end
            PH_ENTRIES: begin
               emit = (csr.format_version == FMT_ENTRIES);
               res.channel      = entry[15:10];
               res.adc_value    = {6'd0, entry[9:0]};
               res.last_in_word = half_ff || (el_dec == 7'd0);
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
   end

   // next parser state
   always_comb begin
      busy_in      = busy_ff;
      word_in      = word_ff;
      phase_in     = phase_ff;
      skip_left_in = skip_left_ff;
      cc_in        = cc_ff;
      pat_in       = pat_ff;
      bo_in        = bo_ff;
      partial_in   = partial_ff;
      el_in        = el_ff;
      card_in      = card_ff;
      off_in       = off_ff;
      half_in      = half_ff;
      if (load) begin
         word_in = q_word.data_word;
         off_in  = q_word.first_of_bank ? 6'd0 : bo_ff;
         half_in = 1'b0;
         busy_in = !(q_word.first_of_bank && csr.skip_extra_header);
      end else if (step_en) begin
         busy_in = 1'b0;
         if (csr.format_version == FMT_PATTERN || csr.format_version == FMT_ENTRIES) begin
            unique case (phase_ff)
               PH_SKIP: begin
                  skip_left_in = skip_left_ff - 6'd1;
                  if (skip_left_ff == 6'd1) begin
                     phase_in = after_trigger(el_ff);
                  end
               end
               PH_PATTERN: begin
                  if (csr.format_version == FMT_PATTERN) begin
                     pat_in   = word_ff;
                     cc_in    = '0;
                     bo_in    = '0;
                     phase_in = PH_DATA;
                  end
               end
               PH_SPLIT: begin
                  if (csr.format_version == FMT_PATTERN) begin
                     cc_in    = cc_next;
                     off_in   = bo_ff;
                     phase_in = PH_DATA;
                     if (cc_done) begin
                        bo_in    = '0;
                        phase_in = PH_HEADER;
                     end else begin
                        busy_in  = 1'b1;
                     end
                  end
               end
               PH_DATA: begin
                  if (csr.format_version == FMT_PATTERN) begin
                     if (off_ff >= 6'd32) begin
                        bo_in = '0;
                     end else if (!pat_bit || off_ff <= 6'd20) begin
                        cc_in  = cc_next;
                        off_in = pat_bit ? off_long : off_short;
                        if (cc_done) begin
                           bo_in    = '0;
                           phase_in = PH_HEADER;
                        end else begin
                           busy_in  = 1'b1;
                        end
                     end else begin
                        partial_in = shifted[7:0];
                        bo_in      = off_ff - 6'd20;
                        phase_in   = PH_SPLIT;
                     end
                  end
               end
               PH_ENTRIES: begin
                  if (csr.format_version == FMT_ENTRIES) begin
                     el_in = el_dec;
                     if (el_dec == 7'd0) begin
                        phase_in = PH_HEADER;
                     end else if (!half_ff) begin
                        half_in = 1'b1;
                        busy_in = 1'b1;
                     end
                  end
               end
               default: begin
                  card_in      = word_ff[22:14];
                  el_in        = el_new;
                  skip_left_in = skip_new;
                  cc_in        = '0;
                  bo_in        = '0;
                  partial_in   = '0;
                  phase_in     = (skip_new != 6'd0) ? PH_SKIP : after_trigger(el_new);
               end
            endcase
         end
      end
      // restart on a new bank or a write to the format register
      if (csr.format_write || (load && q_word.first_of_bank)) begin
         phase_in     = PH_HEADER;
         skip_left_in = '0;
         cc_in        = '0;
         pat_in       = '0;
         bo_in        = '0;
         partial_in   = '0;
         el_in        = '0;
         card_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= PH_HEADER;
         skip_left_ff <= '0;
         cc_ff        <= '0;
         pat_ff       <= '0;
         bo_ff        <= '0;
         partial_ff   <= '0;
         el_ff        <= '0;
         card_ff      <= '0;
         rvalid_ff    <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         skip_left_ff <= skip_left_in;
         cc_ff        <= cc_in;
         pat_ff       <= pat_in;
         bo_ff        <= bo_in;
         partial_ff   <= partial_in;
         el_ff        <= el_in;
         card_ff      <= card_in;
         if (slot_free) begin
            rvalid_ff <= step_en && emit;
         end
      end
   end

   // hold the word payload and the output word
   always_ff @(posedge clock) begin
      word_ff <= word_in;
      off_ff  <= off_in;
      half_ff <= half_in;
      if (slot_free) begin
         rdata_ff <= res;
      end
   end

   assign rsp_valid  = rvalid_ff;
   assign rsp_result = rdata_ff;

   a_split_offset: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SPLIT) |-> (bo_ff != 6'd0 && bo_ff < 6'd12))
      else $error("split offset out of range");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rvalid_ff) |-> $past(busy_ff)) else $error("result without a word");

   a_channel_bound: assert property (@(posedge clock) disable iff (reset)
      cc_ff <= CpcLim) else $error("channel count beyond card");

endmodule

>>> sv/calorimeter_raw_bank_unpacker_top.sv
// Top level of the calorimeter raw bank unpacker.
// Words of a readout bank enter on req_ into a four-word queue; the parser
// then loads one word and works through it in steps: a header, trigger,
// pattern or format 1 word takes one step, a format 2 data word one step
// per decoded channel, plus a closing step when the word runs out before
// the card ends without a split code, a format 3 entry word up to two.
// The single result register on rsp_ takes one result per cycle and
// stalls the parser while a held result waits for rsp_tready. The user
// must see that the format register is written only while the block is
// idle, which the block does not enforce. A write restarts the parser.
module calorimeter_raw_bank_unpacker_top import rbu_pkg::*; #(
   parameter int CHANNELS_PER_CARD = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // data_word
   input  logic        req_tuser,   // first_of_bank
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // card_code, channel, cell_id, adc_value, zero pad
   output logic        rsp_tlast,   // last_in_word
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [1:0]  csr_wdata
);

   logic [1:0] fmt_ff;
   logic       skip_ff;
   csr_type    csr;
   word_type   req_word, q_word;
   logic       q_valid, q_ready;
   result_type result;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff  <= FMT_PATTERN;
         skip_ff <= 1'b0;
      end else if (csr_wen) begin
         unique case (csr_index)
            REG_FORMAT:   fmt_ff  <= csr_wdata;
            REG_SKIP_HDR: skip_ff <= csr_wdata[0];
         endcase
      end
   end

   always_comb begin
      csr.format_version    = fmt_ff;
      csr.skip_extra_header = skip_ff;
      csr.format_write      = csr_wen && (csr_index == REG_FORMAT);
      req_word.data_word     = req_tdata;
      req_word.first_of_bank = req_tuser;
   end

   rbu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_word   (req_word),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_word     (q_word)
   );

   rbu_parser #(.CHANNELS_PER_CARD(CHANNELS_PER_CARD)) u_parser (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_word     (q_word),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   // pack the output word, lowest field first
   assign rsp_tdata = {1'b0, result.adc_value, result.cell_id, result.channel,
                       result.card_code};
   assign rsp_tlast = result.last_in_word;

endmodule
